/* sv/fpap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpap_pkg
// Shared types and constants for the FTP PORT argument parser.
// ----------------------------------------------------------------------------
package fpap_pkg;

  localparam int unsigned AccumW   = 12;
  localparam int unsigned CountW   = 3;
  localparam int unsigned ResultW  = 49;
  localparam int unsigned OutDataW = 56;

  localparam logic [7:0]        CharNul   = 8'h00;
  localparam logic [7:0]        CharComma = 8'h2C;
  localparam logic [7:0]        CharZero  = 8'h30;
  localparam logic [7:0]        CharNine  = 8'h39;
  localparam logic [7:0]        CharSpace = 8'h20;
  localparam logic [7:0]        CharTab   = 8'h09;
  localparam logic [7:0]        CharCr    = 8'h0D;
  localparam logic [AccumW-1:0] AccumMax  = 12'd4095;
  localparam logic [CountW-1:0] CommaMax  = 3'd5;
  localparam logic [CountW-1:0] AddrCount = 3'd4;

  // Per-field parse state.
  typedef struct packed {
    logic [AccumW-1:0] accum;
    logic              seen_digit;
    logic              stopped;
  } fpap_field_t;

  // One parsed result.
  typedef struct packed {
    logic        malformed;
    logic [15:0] port_number;
    logic [31:0] ip_address;
  } fpap_result_t;

endpackage

/* sv/fpap_field.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpap_field
// Next-state logic of one decimal field: skips leading white space,
// accumulates digits with saturation and stops at any other character.
// ----------------------------------------------------------------------------
module fpap_field (
  input  fpap_pkg::fpap_field_t field_i,
  input  logic [7:0]            char_i,
  output fpap_pkg::fpap_field_t field_o
);

  logic        is_digit;
  logic        is_space;
  logic [15:0] times_ten;

  // Character classes.
  assign is_digit = (char_i >= fpap_pkg::CharZero) && (char_i <= fpap_pkg::CharNine);
  assign is_space = (char_i == fpap_pkg::CharSpace) ||
                    ((char_i >= fpap_pkg::CharTab) && (char_i <= fpap_pkg::CharCr));

  // Accumulator times ten plus the digit, built from two shifts.
  assign times_ten = {1'b0, field_i.accum, 3'b000} + {3'b000, field_i.accum, 1'b0} +
                     {12'd0, char_i[3:0]};

  always_comb begin
    field_o = field_i;
    if (!field_i.stopped) begin
      if (is_digit) begin
        field_o.seen_digit = 1'b1;
        field_o.accum = (times_ten > {4'd0, fpap_pkg::AccumMax}) ?
                        fpap_pkg::AccumMax : times_ten[11:0];
      end else if (!(is_space && !field_i.seen_digit)) begin
        field_o.stopped = 1'b1;
      end
    end
  end

endmodule

/* sv/fpap_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpap_out_buf
// Result register with a skid stage, so that the parser keeps taking
// characters while a finished result waits for the downstream side.
// ----------------------------------------------------------------------------
module fpap_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fpap_pkg::fpap_result_t result_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output fpap_pkg::fpap_result_t result_o,
  input  logic                   ready_i
);

  logic                   main_valid_q, main_valid_d;
  logic                   skid_valid_q, skid_valid_d;
  fpap_pkg::fpap_result_t main_q, main_d;
  fpap_pkg::fpap_result_t skid_q, skid_d;

  assign ready_o  = !skid_valid_q;
  assign valid_o  = main_valid_q;
  assign result_o = main_q;

  // Main register refills from the skid stage first, then from the parser.
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || ready_i) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = result_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = result_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // The skid stage only holds data behind a full main register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> main_valid_q)
    else $error("skid stage holds a result while the main register is empty");

endmodule

/* sv/ftp_port_argument_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftp_port_argument_parser_top
// Parses an FTP PORT argument "h1,h2,h3,h4,p1,p2" one character per transfer
// and emits the IPv4 address, port and a malformed flag on the zero byte.
//
// Channel   Dir  Width  Contents
// s_axis    in   8      char_byte
// m_axis    out  56     ip_address, port_number, malformed
//
// One character is taken per cycle while s_axis_tready_o is high; the parse state
// updates in the cycle of the transfer and a terminator loads the result register
// or the skid stage. Reset clears the parse state and empties the result and skid
// registers. A stalled output holds one result in the result register and a second
// in the skid stage; s_axis_tready_o drops only when both are full.
// ----------------------------------------------------------------------------
module ftp_port_argument_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] char_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o   // [31:0] ip_address, [47:32] port_number,
                                       // [48] malformed, [55:49] zero
);

  fpap_pkg::fpap_field_t              field_q, field_d, field_step;
  logic [fpap_pkg::CountW-1:0]        comma_q, comma_d;
  logic [31:0]                        addr_q, addr_d, addr_store;
  logic [fpap_pkg::AccumW-1:0]        port_high_q, port_high_d;
  logic                               ovf_q, ovf_d, ovf_store;
  logic                               accept, is_term, is_comma, in_addr;
  logic [4:0]                         lane_base;
  fpap_pkg::fpap_result_t             result, result_out;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_term  = (s_axis_tdata_i == fpap_pkg::CharNul);
  assign is_comma = (s_axis_tdata_i == fpap_pkg::CharComma) && (comma_q < fpap_pkg::CommaMax);
  assign in_addr  = (comma_q < fpap_pkg::AddrCount);

  fpap_field u_field (
    .field_i (field_q),
    .char_i  (s_axis_tdata_i),
    .field_o (field_step)
  );

  // Current field merged into its address byte; h1 lands in the top byte.
  assign lane_base = {~comma_q[1:0], 3'b000};
  always_comb begin
    addr_store = addr_q;
    addr_store[lane_base +: 8] = addr_q[lane_base +: 8] | field_q.accum[7:0];
  end
  assign ovf_store = ovf_q || (field_q.accum > 12'd255);

  // Result of a terminator.
  always_comb begin
    result.ip_address  = in_addr ? addr_store : addr_q;
    result.port_number = in_addr ? 16'd0 :
                         ({port_high_q[7:0], 8'd0} + {4'd0, field_q.accum});
    result.malformed   = (comma_q < fpap_pkg::CommaMax) || (in_addr ? ovf_store : ovf_q);
  end

  // Parse state update for one character.
  always_comb begin
    field_d     = field_q;
    comma_d     = comma_q;
    addr_d      = addr_q;
    port_high_d = port_high_q;
    ovf_d       = ovf_q;
    if (accept) begin
      if (is_term) begin
        field_d     = '0;
        comma_d     = '0;
        addr_d      = '0;
        port_high_d = '0;
        ovf_d       = 1'b0;
      end else if (is_comma) begin
        if (in_addr) begin
          addr_d = addr_store;
          ovf_d  = ovf_store;
        end else begin
          port_high_d = field_q.accum;
        end
        comma_d = comma_q + 3'd1;
        field_d = '0;
      end else begin
        field_d = field_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q     <= '0;
      comma_q     <= '0;
      addr_q      <= '0;
      port_high_q <= '0;
      ovf_q       <= 1'b0;
    end else begin
      field_q     <= field_d;
      comma_q     <= comma_d;
      addr_q      <= addr_d;
      port_high_q <= port_high_d;
      ovf_q       <= ovf_d;
    end
  end

  fpap_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept && is_term),
    .result_i (result),
    .ready_o  (s_axis_tready_o),
    .valid_o  (m_axis_tvalid_o),
    .result_o (result_out),
    .ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {{(fpap_pkg::OutDataW - fpap_pkg::ResultW){1'b0}}, result_out};

  // The comma count never passes five.
  assert property (@(posedge clk_i) disable iff (!rst_ni) comma_q <= fpap_pkg::CommaMax)
    else $error("comma count above five");

  // A terminator returns the parse state to its reset values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && is_term) |=> (comma_q == '0 && addr_q == '0 && !ovf_q))
    else $error("parse state not cleared after terminator");

  // Input back-pressure only arises behind a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

endmodule
